FILE: hdl/medt_pkg.sv
// ----------------------------------------------------------------------------
// medt_pkg
// Types and codes used by mesh_edge_dedup_table and its testbench.
// ----------------------------------------------------------------------------
package medt_pkg;

   localparam int NODE_W  = 20;
   localparam int TAG_W   = 16;
   localparam int EID_W   = 12;
   localparam int STAT_W  = 3;

   typedef enum logic [1:0] {
      MODE_TRI   = 2'd0,
      MODE_SEG   = 2'd1,
      MODE_READ  = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_REPEAT    = 3'd1,
      ST_FULL      = 3'd2,
      ST_UNMATCHED = 3'd3,
      ST_UNUSED    = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]        mode;
      logic [NODE_W-1:0] node_a;
      logic [NODE_W-1:0] node_b;
      logic [NODE_W-1:0] node_c;
      logic [TAG_W-1:0]  segment_tag;
      logic [EID_W-1:0]  read_index;
   } req_type;

   typedef struct packed {
      logic [EID_W-1:0]  edge_id;
      logic              reversed;
      logic              created;
      logic [NODE_W-1:0] low_node;
      logic [NODE_W-1:0] high_node;
      logic [1:0]        incidence;
      logic              on_boundary;
      logic [TAG_W-1:0]  edge_tag;
      logic [STAT_W-1:0] status;
      logic              last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_KEY,
      S_PROBE,
      S_EDGE,
      S_EDGE_WR,
      S_EMIT,
      S_READ,
      S_READ_WAIT
   } state_type;

endpackage

FILE: hdl/medt_hash_table.sv
// ----------------------------------------------------------------------------
// medt_hash_table
// Open-addressed key memory: sorted node pair -> edge id, with epoch marks.
// ----------------------------------------------------------------------------
module medt_hash_table #(
   parameter int SLOT_BITS = 13,
   parameter int KEY_W     = 40,
   parameter int ID_W      = 12,
   parameter int EPOCH_W   = 8
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [SLOT_BITS-1:0] rd_addr,
   output logic               rd_used,
   output logic [KEY_W-1:0]   rd_key,
   output logic [ID_W-1:0]    rd_id,
   input  logic               wr_en,
   input  logic [SLOT_BITS-1:0] wr_addr,
   input  logic [KEY_W-1:0]   wr_key,
   input  logic [ID_W-1:0]    wr_id,
   input  logic [EPOCH_W-1:0] epoch
);
   localparam int DEPTH = 1 << SLOT_BITS;
   localparam int ENT_W = EPOCH_W + KEY_W + ID_W;

   logic [ENT_W-1:0] mem [DEPTH];
   logic [ENT_W-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {epoch, wr_key, wr_id};
      end
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   assign rd_used = (q_ff[ENT_W-1 -: EPOCH_W] == epoch);
   assign rd_key  = q_ff[ID_W +: KEY_W];
   assign rd_id   = q_ff[ID_W-1:0];
endmodule

FILE: hdl/medt_edge_store.sv
// ----------------------------------------------------------------------------
// medt_edge_store
// Per-edge record memory: endpoints, incidence, segment mark and tag.
// ----------------------------------------------------------------------------
module medt_edge_store #(
   parameter int ID_W  = 12,
   parameter int REC_W = 59
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [ID_W-1:0]  rd_addr,
   output logic [REC_W-1:0] rd_data,
   input  logic             wr_en,
   input  logic [ID_W-1:0]  wr_addr,
   input  logic [REC_W-1:0] wr_data
);
   logic [REC_W-1:0] mem [1 << ID_W];
   logic [REC_W-1:0] q_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff <= mem[rd_addr];
      end
   end

   assign rd_data = q_ff;
endmodule

FILE: hdl/mesh_edge_dedup_table.sv
// ----------------------------------------------------------------------------
// mesh_edge_dedup_table
// Global edge table of a triangle mesh: dedup by sorted node pair.
//
//   channel | dir | beat
//   req_    | in  | req_type: mode, nodes, segment tag, read index
//   rsp_    | out | rsp_type: one beat per local edge, last on the final one
//
// Per local edge a triangle steps S_KEY, S_PROBE, S_EDGE_WR, S_EMIT if new,
// adds S_EDGE after S_PROBE if known, goes S_PROBE to S_EMIT if full, and
// stays in S_PROBE per extra hash probe. Segments take the same path for one
// edge, S_KEY to S_EMIT with equal ends; reads pass S_READ, S_READ_WAIT.
// After reset and every 255th clear the key memory is swept a slot a cycle;
// other clears bump the epoch. Stalled rsp_ holds S_EMIT, next beat staged.
// ----------------------------------------------------------------------------
module mesh_edge_dedup_table #(
   parameter int MAX_EDGES    = 4096,
   parameter int NODE_ID_BITS = 20,
   parameter int TAG_BITS     = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  medt_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output medt_pkg::rsp_type    rsp_data
);
   import medt_pkg::*;

   localparam int ID_W      = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int CNT_W     = $clog2(MAX_EDGES + 1);
   localparam int SLOT_BITS = ID_W + 1;
   localparam int KEY_W     = 2 * NODE_ID_BITS;
   localparam int EPOCH_W   = 8;
   localparam int REC_W     = KEY_W + 2 + 1 + TAG_BITS;

   typedef struct packed {
      logic [NODE_ID_BITS-1:0] lo;
      logic [NODE_ID_BITS-1:0] hi;
      logic [1:0]              inc;
      logic                    mark;
      logic [TAG_BITS-1:0]     tag;
   } rec_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   rsp_type   out_ff, out_in;
   rsp_type   beat_ff, beat_in;
   logic      out_v_ff, out_v_in;
   logic [1:0] k_ff, k_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [EPOCH_W-1:0] epoch_ff, epoch_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic [ID_W-1:0] id_ff, id_in;
   logic created_ff, created_in;
   logic [NODE_ID_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic rev_ff, rev_in;
   rec_type rec_ff, rec_in;

   logic ht_rd, ht_wr, ht_used;
   logic [SLOT_BITS-1:0] ht_raddr, ht_waddr;
   logic [KEY_W-1:0] ht_key, ht_wkey;
   logic [ID_W-1:0] ht_id, ht_wid;
   logic es_rd, es_wr;
   logic [ID_W-1:0] es_raddr, es_waddr;
   logic [REC_W-1:0] es_q, es_wdata;
   rec_type es_rec;

   medt_hash_table #(
      .SLOT_BITS(SLOT_BITS), .KEY_W(KEY_W), .ID_W(ID_W), .EPOCH_W(EPOCH_W)
   ) u_hash (
      .clock(clock), .rd_en(ht_rd), .rd_addr(ht_raddr), .rd_used(ht_used),
      .rd_key(ht_key), .rd_id(ht_id), .wr_en(ht_wr), .wr_addr(ht_waddr),
      .wr_key(ht_wkey), .wr_id(ht_wid), .epoch(epoch_ff)
   );

   medt_edge_store #(.ID_W(ID_W), .REC_W(REC_W)) u_store (
      .clock(clock), .rd_en(es_rd), .rd_addr(es_raddr), .rd_data(es_q),
      .wr_en(es_wr), .wr_addr(es_waddr), .wr_data(es_wdata)
   );
   assign es_rec = rec_type'(es_q);

   logic [NODE_ID_BITS-1:0] na, nb, nc, f_n, s_n;
   logic [SLOT_BITS-1:0] hash_v;
   logic [KEY_W-1:0] key_cur;
   assign na = req_ff.node_a[NODE_ID_BITS-1:0];
   assign nb = req_ff.node_b[NODE_ID_BITS-1:0];
   assign nc = req_ff.node_c[NODE_ID_BITS-1:0];
   assign key_cur = {lo_ff, hi_ff};

   always_comb begin
      case (k_ff)
         2'd0:    begin f_n = na; s_n = nb; end
         2'd1:    begin f_n = nb; s_n = nc; end
         default: begin f_n = nc; s_n = na; end
      endcase
   end

   // fold the key down to a slot address
   always_comb begin
      logic [KEY_W+SLOT_BITS-1:0] ext;
      ext = {{SLOT_BITS{1'b0}}, f_n < s_n ? {f_n, s_n} : {s_n, f_n}};
      hash_v = '0;
      for (int i = 0; i < KEY_W; i += SLOT_BITS) begin
         hash_v = hash_v ^ ext[i +: SLOT_BITS];
      end
      hash_v = hash_v ^ {ext[SLOT_BITS-2:0], 1'b0};
   end

   function automatic rsp_type edge_rsp(input logic [ID_W-1:0] id, input logic rv,
                                        input logic cr, input rec_type r);
      rsp_type o;
      o = '0;
      o.edge_id     = EID_W'(id);
      o.reversed    = rv;
      o.created     = cr;
      o.low_node    = NODE_W'(r.lo);
      o.high_node   = NODE_W'(r.hi);
      o.incidence   = r.inc;
      o.on_boundary = (r.inc == 2'd1) || r.mark;
      o.edge_tag    = TAG_W'(r.tag);
      return o;
   endfunction

   assign req_ready = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         out_v_ff <= 1'b0;
         count_ff <= '0;
         epoch_ff <= '0;
         slot_ff  <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         out_v_ff <= out_v_in;
         count_ff <= count_in;
         epoch_ff <= epoch_in;
         slot_ff  <= slot_in;
         k_ff     <= k_in;
      end
      req_ff     <= req_in;
      out_ff     <= out_in;
      beat_ff    <= beat_in;
      id_ff      <= id_in;
      created_ff <= created_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      rev_ff     <= rev_in;
      rec_ff     <= rec_in;
   end

   always_comb begin
      rec_type r;
      logic [ID_W-1:0] idx;
      state_in = state_ff;
      out_v_in = out_v_ff && !rsp_ready;
      out_in = out_ff;
      beat_in = beat_ff;
      req_in = req_ff;
      k_in = k_ff;
      count_in = count_ff;
      epoch_in = epoch_ff;
      slot_in = slot_ff;
      id_in = id_ff;
      created_in = created_ff;
      lo_in = lo_ff;
      hi_in = hi_ff;
      rev_in = rev_ff;
      rec_in = rec_ff;
      ht_rd = 1'b0; ht_raddr = slot_ff;
      ht_wr = 1'b0; ht_waddr = slot_ff; ht_wkey = key_cur; ht_wid = id_ff;
      es_rd = 1'b0; es_raddr = id_ff;
      es_wr = 1'b0; es_waddr = id_ff; es_wdata = REC_W'(rec_ff);
      r = '0;
      idx = req_ff.read_index[ID_W-1:0];
      unique case (state_ff)
         S_CLEAR: begin
            // stamp every slot with a stale epoch
            ht_wr = 1'b1;
            ht_waddr = slot_ff;
            ht_wkey = '0;
            ht_wid = '0;
            epoch_in = epoch_ff;
            slot_in = slot_ff + 1'b1;
            if (slot_ff == '1) begin
               epoch_in = epoch_ff + 1'b1;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid && req_ready) begin
               req_in = req_valid ? req_data : req_ff;
               k_in = '0;
               state_in = S_KEY;
            end
         end
         S_KEY: begin
            lo_in = (f_n < s_n) ? f_n : s_n;
            hi_in = (f_n < s_n) ? s_n : f_n;
            rev_in = (f_n > s_n);
            slot_in = hash_v;
            beat_in = '0;
            beat_in.last = 1'b1;
            unique case (mode_type'(req_ff.mode))
               MODE_TRI: begin
                  if (na == nb || nb == nc || nc == na) begin
                     beat_in.status = ST_REPEAT;
                     state_in = S_EMIT;
                  end else begin
                     ht_rd = 1'b1; ht_raddr = hash_v;
                     state_in = S_PROBE;
                  end
               end
               MODE_SEG: begin
                  if (na == nb) begin
                     beat_in.status = ST_UNMATCHED;
                     beat_in.reversed = 1'b0;
                     beat_in.low_node = NODE_W'(na);
                     beat_in.high_node = NODE_W'(na);
                     state_in = S_EMIT;
                  end else begin
                     ht_rd = 1'b1; ht_raddr = hash_v;
                     state_in = S_PROBE;
                  end
               end
               MODE_READ: begin
                  if (CNT_W'(req_ff.read_index) >= count_ff ||
                      (EID_W > ID_W && (req_ff.read_index >> ID_W) != '0)) begin
                     beat_in.status = ST_UNUSED;
                     state_in = S_EMIT;
                  end else begin
                     es_rd = 1'b1; es_raddr = idx;
                     id_in = idx;
                     state_in = S_READ;
                  end
               end
               MODE_CLEAR: begin
                  count_in = '0;
                  epoch_in = epoch_ff + 1'b1;
                  slot_in = '0;
                  if (epoch_ff == '1) begin
                     state_in = S_CLEAR;
                     out_in = beat_in;
                     out_v_in = 1'b1;
                  end else begin
                     state_in = S_EMIT;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_PROBE: begin
            created_in = 1'b0;
            if (ht_used && ht_key == key_cur) begin
               id_in = ht_id;
               es_rd = 1'b1; es_raddr = ht_id;
               state_in = S_EDGE;
            end else if (ht_used) begin
               slot_in = slot_ff + 1'b1;
               ht_rd = 1'b1; ht_raddr = slot_ff + 1'b1;
            end else if (mode_type'(req_ff.mode) == MODE_SEG) begin
               beat_in.status = ST_UNMATCHED;
               beat_in.reversed = rev_ff;
               beat_in.low_node = NODE_W'(lo_ff);
               beat_in.high_node = NODE_W'(hi_ff);
               beat_in.last = 1'b1;
               state_in = S_EMIT;
            end else if (count_ff >= CNT_W'(MAX_EDGES)) begin
               beat_in = '0;
               beat_in.status = ST_FULL;
               beat_in.reversed = rev_ff;
               beat_in.low_node = NODE_W'(lo_ff);
               beat_in.high_node = NODE_W'(hi_ff);
               beat_in.last = (k_ff == 2'd2);
               state_in = S_EMIT;
            end else begin
               // insert a new edge
               id_in = count_ff[ID_W-1:0];
               ht_wr = 1'b1; ht_waddr = slot_ff;
               ht_wkey = key_cur; ht_wid = count_ff[ID_W-1:0];
               count_in = count_ff + 1'b1;
               created_in = 1'b1;
               r.lo = lo_ff; r.hi = hi_ff; r.inc = 2'd1;
               rec_in = r;
               state_in = S_EDGE_WR;
            end
         end
         S_EDGE: begin
            r = es_rec;
            if (mode_type'(req_ff.mode) == MODE_SEG) begin
               r.mark = 1'b1;
               if (req_ff.segment_tag[TAG_BITS-1:0] != '0) begin
                  r.tag = req_ff.segment_tag[TAG_BITS-1:0];
               end
            end else if (r.inc != 2'd2) begin
               r.inc = r.inc + 2'd1;
            end
            rec_in = r;
            state_in = S_EDGE_WR;
         end
         S_EDGE_WR: begin
            es_wr = 1'b1;
            beat_in = edge_rsp(id_ff, rev_ff, created_ff, rec_ff);
            beat_in.last = (mode_type'(req_ff.mode) == MODE_SEG) || (k_ff == 2'd2);
            state_in = S_EMIT;
         end
         S_READ: begin
            state_in = S_READ_WAIT;
         end
         S_READ_WAIT: begin
            beat_in = edge_rsp(id_ff, 1'b0, 1'b0, es_rec);
            beat_in.last = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!out_v_ff) begin
               out_in = beat_ff;
               out_v_in = 1'b1;
               if (beat_ff.last) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
                  state_in = S_KEY;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for mesh_edge_dedup_table. A scoreboard class keeps its
// own copy of the edge table, predicts the response beats of every accepted
// request beat and checks each response beat in order. The stimulus is a
// directed set, a random mix of triangles, segments, reads and clears over a
// small node pool, and a short tail with no idling.
// ----------------------------------------------------------------------------
module testbench;
   import medt_pkg::*;

   localparam int TABLE_DEPTH = 4096;
   localparam int CYCLE_LIMIT = 3000000;

   class edge_scoreboard;
      rsp_type    pending_q[$];
      int         slot_of[bit [2*NODE_W-1:0]];
      bit [NODE_W-1:0] low_of[TABLE_DEPTH];
      bit [NODE_W-1:0] high_of[TABLE_DEPTH];
      bit [1:0]   hits_of[TABLE_DEPTH];
      bit         marked[TABLE_DEPTH];
      bit [TAG_W-1:0] tag_of[TABLE_DEPTH];
      int         edge_total;
      int         errors;

      function new();
         errors = 0;
         wipe();
      endfunction

      function void wipe();
         slot_of.delete();
         edge_total = 0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            low_of[i] = '0;
            high_of[i] = '0;
            hits_of[i] = '0;
            marked[i] = 1'b0;
            tag_of[i] = '0;
         end
      endfunction

      function rsp_type blank(status_type st);
         rsp_type r;
         r = '0;
         r.status = st;
         return r;
      endfunction

      function rsp_type describe(int id, bit rev, bit cre);
         rsp_type r;
         r = '0;
         r.edge_id = id[EID_W-1:0];
         r.reversed = rev;
         r.created = cre;
         r.low_node = low_of[id];
         r.high_node = high_of[id];
         r.incidence = hits_of[id];
         r.on_boundary = (hits_of[id] == 2'd1) || marked[id];
         r.edge_tag = tag_of[id];
         r.status = ST_OK;
         return r;
      endfunction

      function void note_request(req_type q);
         rsp_type beats[$];
         bit [NODE_W-1:0] n[3];
         bit [NODE_W-1:0] f, s, lo, hi;
         bit rev, cre;
         int id;
         n[0] = q.node_a;
         n[1] = q.node_b;
         n[2] = q.node_c;
         case (mode_type'(q.mode))
            MODE_TRI: begin
               if (n[0] == n[1] || n[1] == n[2] || n[2] == n[0]) begin
                  beats = {beats, blank(ST_REPEAT)};
               end else begin
                  for (int k = 0; k < 3; k++) begin
                     f = n[k];
                     s = n[(k + 1) % 3];
                     lo = (f < s) ? f : s;
                     hi = (f < s) ? s : f;
                     rev = (f != lo);
                     cre = 1'b0;
                     if (slot_of.exists({lo, hi})) begin
                        id = slot_of[{lo, hi}];
                     end else if (edge_total >= TABLE_DEPTH) begin
                        beats = {beats, blank(ST_FULL)};
                        beats[$].reversed = rev;
                        beats[$].low_node = lo;
                        beats[$].high_node = hi;
                        continue;
                     end else begin
                        id = edge_total;
                        slot_of[{lo, hi}] = id;
                        low_of[id] = lo;
                        high_of[id] = hi;
                        hits_of[id] = '0;
                        marked[id] = 1'b0;
                        tag_of[id] = '0;
                        edge_total++;
                        cre = 1'b1;
                     end
                     if (hits_of[id] < 2'd2)
                        hits_of[id]++;
                     beats = {beats, describe(id, rev, cre)};
                  end
               end
            end
            MODE_SEG: begin
               lo = (n[0] < n[1]) ? n[0] : n[1];
               hi = (n[0] < n[1]) ? n[1] : n[0];
               rev = (n[0] != lo);
               if (lo == hi || !slot_of.exists({lo, hi})) begin
                  beats = {beats, blank(ST_UNMATCHED)};
                  beats[$].reversed = rev;
                  beats[$].low_node = lo;
                  beats[$].high_node = hi;
               end else begin
                  id = slot_of[{lo, hi}];
                  marked[id] = 1'b1;
                  if (q.segment_tag != '0)
                     tag_of[id] = q.segment_tag;
                  beats = {beats, describe(id, rev, 1'b0)};
               end
            end
            MODE_READ: begin
               if (int'(q.read_index) >= edge_total)
                  beats = {beats, blank(ST_UNUSED)};
               else
                  beats = {beats, describe(int'(q.read_index), 1'b0, 1'b0)};
            end
            default: begin
               wipe();
               beats = {beats, blank(ST_OK)};
            end
         endcase
         beats[$].last = 1'b1;
         pending_q = {pending_q, beats};
      endfunction

      function void report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endfunction

      function void compare(string field, longint got, longint want);
         if (got != want)
            report($sformatf("%s got %0h expected %0h", field, got, want));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected beat %h", got));
            return;
         end
         want = pending_q.pop_front();
         compare("edge_id", got.edge_id, want.edge_id);
         compare("reversed", got.reversed, want.reversed);
         compare("created", got.created, want.created);
         compare("low_node", got.low_node, want.low_node);
         compare("high_node", got.high_node, want.high_node);
         compare("incidence", got.incidence, want.incidence);
         compare("on_boundary", got.on_boundary, want.on_boundary);
         compare("edge_tag", got.edge_tag, want.edge_tag);
         compare("status", got.status, want.status);
         compare("last", got.last, want.last);
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   edge_scoreboard sb;
   bit  calm;
   int  cycles;
   int  stall_left;

   mesh_edge_dedup_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      sb = new();
      calm = 1'b0;
      cycles = 0;
      stall_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      if (!reset && req_valid && req_ready)
         sb.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_data);
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send(req_type q);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic req_type make(mode_type m, int a, int b, int c,
                                    int tag = 0, int idx = 0);
      req_type q;
      q.mode = m;
      q.node_a = a[NODE_W-1:0];
      q.node_b = b[NODE_W-1:0];
      q.node_c = c[NODE_W-1:0];
      q.segment_tag = tag[TAG_W-1:0];
      q.read_index = idx[EID_W-1:0];
      return q;
   endfunction

   function automatic int pick_node();
      case ($urandom_range(0, 7)) inside
         0: return $urandom_range(0, 20'hFFFFF);
         [1:2]: return 20'hFFFFF - $urandom_range(0, 7);
         default: return $urandom_range(0, 9);
      endcase
   endfunction

   function automatic req_type random_request();
      req_type q;
      int id;
      int pick;
      q.node_a = NODE_W'(pick_node());
      q.node_b = NODE_W'(pick_node());
      q.node_c = NODE_W'(pick_node());
      q.segment_tag = ($urandom_range(0, 3) == 0) ? '0 : TAG_W'($urandom_range(0, 16'hFFFF));
      q.read_index = EID_W'($urandom_range(0, 12'hFFF));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         q.mode = MODE_TRI;
      end else if (pick < 77) begin
         q.mode = MODE_SEG;
         if (sb.edge_total > 0 && $urandom_range(0, 3) != 0) begin
            id = $urandom_range(0, sb.edge_total - 1);
            q.node_a = $urandom_range(0, 1) ? sb.low_of[id] : sb.high_of[id];
            q.node_b = (q.node_a == sb.low_of[id]) ? sb.high_of[id] : sb.low_of[id];
         end
      end else if (pick < 97) begin
         q.mode = MODE_READ;
         if (sb.edge_total > 0 && $urandom_range(0, 4) != 0)
            q.read_index = EID_W'($urandom_range(0, sb.edge_total - 1));
      end else begin
         q.mode = MODE_CLEAR;
      end
      return q;
   endfunction

   initial begin
      int settle;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send(make(MODE_READ, 0, 0, 0, 0, 0));
      send(make(MODE_SEG, 2, 3, 0, 16'h1234));
      send(make(MODE_TRI, 1, 2, 3));
      send(make(MODE_TRI, 3, 2, 4));
      send(make(MODE_TRI, 1, 2, 3));
      send(make(MODE_TRI, 2, 1, 3));
      send(make(MODE_TRI, 5, 5, 6));
      send(make(MODE_TRI, 1, 2, 1));
      send(make(MODE_TRI, 7, 8, 8));
      send(make(MODE_TRI, 20'hFFFFF, 0, 20'hFFFFE));
      send(make(MODE_SEG, 3, 2, 0, 16'hFFFF));
      send(make(MODE_SEG, 2, 3, 0, 0));
      send(make(MODE_SEG, 0, 20'hFFFFF, 0, 16'h0001));
      send(make(MODE_SEG, 9, 10, 0, 16'h00AA));
      send(make(MODE_SEG, 4, 4, 0, 16'h00AA));
      send(make(MODE_READ, 0, 0, 0, 0, 0));
      send(make(MODE_READ, 0, 0, 0, 0, 4));
      send(make(MODE_READ, 0, 0, 0, 0, 8));
      send(make(MODE_READ, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 12'hFFF));
      send(make(MODE_CLEAR, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 12'hFFF));
      send(make(MODE_READ, 0, 0, 0, 0, 0));
      send(make(MODE_SEG, 1, 2, 0, 16'h5555));
      send(make(MODE_TRI, 1, 2, 3));

      repeat (100) send(random_request());

      calm = 1'b1;
      send(make(MODE_CLEAR, 0, 0, 0));
      send(make(MODE_TRI, 100001, 100000, 7));
      send(make(MODE_TRI, 11, 12, 13));
      send(make(MODE_READ, 0, 0, 0, 0, 12'hFFF));
      send(make(MODE_SEG, 100002, 100001, 0, 16'h8001));
      send(make(MODE_SEG, 11, 12, 0, 16'h8001));
      send(make(MODE_CLEAR, 0, 0, 0));
      send(make(MODE_READ, 0, 0, 0, 0, 0));
      req_valid <= 1'b0;

      while (sb.pending_q.size() != 0)
         @(posedge clock);
      settle = 0;
      while (settle < 50) begin
         @(posedge clock);
         settle++;
      end
      if (sb.pending_q.size() != 0)
         sb.report($sformatf("%0d beats never arrived", sb.pending_q.size()));
      if (sb.errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
